/* design/bpa_pkg.sv */
// Shared types and constants for the bitmap page allocator.
`default_nettype none
package bpa_pkg;

   localparam int CFG_W     = 14;
   localparam int CSR_IDX_W = 2;
   localparam int OP_W      = 3;
   localparam int LEN_W     = 14;
   localparam int PIDX_W    = 13;
   localparam int ADDR_W    = 32;

   localparam logic [CFG_W-1:0] LIMIT_RESET = 14'd8192;
   localparam logic [CFG_W-1:0] SPLIT_RESET = 14'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SPLIT = 2'd1;

   localparam logic [OP_W-1:0] OP_KERNEL_SINGLE = 3'd0;
   localparam logic [OP_W-1:0] OP_KERNEL_RUN    = 3'd1;
   localparam logic [OP_W-1:0] OP_USER_SINGLE   = 3'd2;
   localparam logic [OP_W-1:0] OP_USER_RUN      = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE       = 3'd4;

   localparam logic [7:0] BYTE_ALL_USED = 8'hFF;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic rel;
      logic setup;
      logic scan;
      logic mark_init;
      logic mark;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_release;
      logic req_alloc;
      logic setup_ok;
      logic found;
      logic scan_last;
      logic mark_last;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

/* design/bpa_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                    wr_data,
   input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                    rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* design/bpa_ctrl.sv */
// Sequencer for clearing, release, search and marking.
`default_nettype none
module bpa_ctrl import bpa_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_REL     = 3'd2;
   localparam logic [2:0] S_SETUP   = 3'd3;
   localparam logic [2:0] S_SCAN    = 3'd4;
   localparam logic [2:0] S_MARKRD  = 3'd5;
   localparam logic [2:0] S_MARK    = 3'd6;
   localparam logic [2:0] S_RESP    = 3'd7;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.req_release)    state_in = S_REL;
               else if (sts.req_alloc) state_in = S_SETUP;
               else                    state_in = S_RESP;
            end
         end
         S_REL: begin
            cmd.rel  = 1'b1;
            state_in = S_RESP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.setup_ok ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.found)          state_in = S_MARKRD;
            else if (sts.scan_last) state_in = S_RESP;
         end
         S_MARKRD: begin
            cmd.mark_init = 1'b1;
            state_in      = S_MARK;
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            if (sts.mark_last) state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end
endmodule
`default_nettype wire

/* design/bpa_dpath.sv */
// Bitmap store, scan and mark datapath, counters and result register.
`default_nettype none
module bpa_dpath import bpa_pkg::*; #(
   parameter int          NUM_PAGES    = 8192,
   parameter int          PAGE_SHIFT   = 12,
   parameter logic [31:0] BASE_ADDRESS = 32'h0010_0000
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [LEN_W-1:0]     req_run_length,
   input  wire logic [PIDX_W-1:0]    req_page_index,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ADDR_W-1:0]         rsp_address,
   output logic                      rsp_granted,
   output logic [CFG_W-1:0]          rsp_free_count,
   input  wire cmd_type              cmd,
   output sts_type                   sts
);
   localparam int CW  = $clog2(NUM_PAGES + 1);
   localparam int PW  = $clog2(NUM_PAGES);
   localparam int NB  = (NUM_PAGES + 7) / 8;
   localparam int BAW = (NB > 1) ? $clog2(NB) : 1;
   localparam int QW  = BAW + 3;
   localparam int MW  = (QW > CW) ? QW : CW;

   logic [CFG_W-1:0]  limit_ff, split_ff;
   logic [CW-1:0]     free_total_ff;
   logic [OP_W-1:0]   op_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [PIDX_W-1:0] pidx_ff;
   logic [CW-1:0]     lo_ff, hi_ff, want_ff, run_ff;
   logic [BAW-1:0]    b_ff, last_b_ff;
   logic [PW-1:0]     start_ff, end_ff;
   logic              ok_ff;
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_address_ff;
   logic              rsp_granted_ff;
   logic [CFG_W-1:0]  rsp_free_count_ff;

   logic [BAW-1:0] rd_addr, wr_addr;
   logic [7:0]     rd_data, wr_data, mark_mask;
   logic           wr_en, rel_hit, single;
   logic [CW-1:0]  limit_c, split_c, want_c;
   logic [CW-1:0]  run_v;
   logic [PW-1:0]  start_v;
   logic           found_v;

   function automatic logic [CW-1:0] clamp_pages(input logic [CFG_W-1:0] v);
      if (32'(v) > NUM_PAGES) clamp_pages = CW'(NUM_PAGES);
      else                    clamp_pages = CW'(v);
   endfunction

   assign limit_c = clamp_pages(limit_ff);
   assign split_c = clamp_pages(split_ff);
   assign single  = !op_ff[0];
   assign want_c  = single ? CW'(1) : CW'(len_ff);

   // first-fit step over one byte of the map
   always_comb begin
      logic [MW-1:0] p;
      run_v   = run_ff;
      start_v = start_ff;
      found_v = 1'b0;
      for (int k = 0; k < 8; k++) begin
         p = MW'({b_ff, 3'(k)});
         if (!found_v) begin
            if (p >= MW'(lo_ff) && p < MW'(hi_ff) && !rd_data[k]) begin
               if (run_v == '0) start_v = PW'(p);
               run_v = run_v + CW'(1);
               if (run_v == want_ff) found_v = 1'b1;
            end else begin
               run_v = '0;
            end
         end
      end
   end

   always_comb begin
      logic [MW-1:0] p;
      for (int k = 0; k < 8; k++) begin
         p = MW'({b_ff, 3'(k)});
         mark_mask[k] = (p >= MW'(start_ff)) && (p <= MW'(end_ff));
      end
   end

   assign rel_hit = rd_data[pidx_ff[2:0]];

   always_comb begin
      if (cmd.setup)                 rd_addr = BAW'(lo_ff >> 3);
      else if (cmd.scan || cmd.mark) rd_addr = b_ff + BAW'(1);
      else if (cmd.mark_init)        rd_addr = BAW'(start_ff >> 3);
      else                           rd_addr = BAW'(req_page_index >> 3);
   end

   always_comb begin
      wr_en   = cmd.clear_wr || cmd.mark || (cmd.rel && rel_hit);
      wr_addr = cmd.rel ? BAW'(pidx_ff >> 3) : b_ff;
      if (cmd.clear_wr)  wr_data = BYTE_ALL_USED;
      else if (cmd.mark) wr_data = rd_data | mark_mask;
      else               wr_data = rd_data & ~(8'b1 << pidx_ff[2:0]);
   end

   bpa_ram #(.WIDTH(8), .DEPTH(NB)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sts             = '0;
      sts.clear_last  = (b_ff == BAW'(NB - 1));
      sts.req_release = (req_operation == OP_RELEASE) && (32'(req_page_index) < NUM_PAGES);
      sts.req_alloc   = (req_operation <= OP_USER_RUN);
      sts.setup_ok    = (hi_ff > lo_ff) &&
                        (single || (len_ff != '0 && 32'(len_ff) <= 32'(free_total_ff)));
      sts.found       = found_v;
      sts.scan_last   = (b_ff == last_b_ff);
      sts.mark_last   = (b_ff == BAW'(end_ff >> 3));
      sts.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         split_ff      <= SPLIT_RESET;
         free_total_ff <= '0;
         b_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_PAGE_LIMIT)   limit_ff <= csr_data;
         if (csr_valid && csr_index == CSR_REGION_SPLIT) split_ff <= csr_data;

         if (cmd.clear_wr || cmd.scan || cmd.mark) b_ff <= b_ff + BAW'(1);
         else if (cmd.setup)                     b_ff <= BAW'(lo_ff >> 3);
         else if (cmd.mark_init)                 b_ff <= BAW'(start_ff >> 3);

         if (cmd.rel && rel_hit)                 free_total_ff <= free_total_ff + CW'(1);
         else if (cmd.mark && sts.mark_last)     free_total_ff <= free_total_ff - want_ff;

         if (cmd.load_rsp)                       rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)    rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_operation;
         len_ff  <= req_run_length;
         pidx_ff <= req_page_index;
         ok_ff   <= 1'b0;
         if (!req_operation[1]) begin
            lo_ff <= '0;
            hi_ff <= (split_c < limit_c) ? split_c : limit_c;
         end else begin
            lo_ff <= split_c;
            hi_ff <= limit_c;
         end
      end
      if (cmd.setup) begin
         want_ff   <= want_c;
         last_b_ff <= BAW'((hi_ff - CW'(1)) >> 3);
         run_ff    <= '0;
      end
      if (cmd.scan) begin
         run_ff   <= run_v;
         start_ff <= start_v;
      end
      if (cmd.mark_init) end_ff <= PW'(MW'(start_ff) + MW'(want_ff) - MW'(1));
      if ((cmd.rel && rel_hit) || (cmd.mark && sts.mark_last)) ok_ff <= 1'b1;
      if (cmd.load_rsp) begin
         rsp_granted_ff    <= ok_ff;
         rsp_free_count_ff <= CFG_W'(free_total_ff);
         if (ok_ff && op_ff <= OP_USER_RUN)
            rsp_address_ff <= BASE_ADDRESS + ADDR_W'(64'(start_ff) << PAGE_SHIFT);
         else
            rsp_address_ff <= '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_address    = rsp_address_ff;
   assign rsp_granted    = rsp_granted_ff;
   assign rsp_free_count = rsp_free_count_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= CW'(NUM_PAGES))
      else $error("free count above page count");
   a_mark_debit: assert property (@(posedge clock) disable iff (reset)
      cmd.mark && sts.mark_last |=> free_total_ff == $past(free_total_ff - want_ff))
      else $error("run not debited from free count");
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff && rsp_granted_ff == $past(ok_ff))
      else $error("result register not loaded");
endmodule
`default_nettype wire

/* design/bitmap_page_allocator_unit.sv */
// Top level of the bitmap page frame allocator.
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | operation, run_length, page_index
//  rsp_    | out       | rsp_valid/rsp_stall | address, granted, free_count
//  csr_    | in        | csr_valid/csr_ready | index (0 page_limit, 1 region_split), data
//
// Steps: a release reads and clears the page's map bit; an unknown op goes straight
//   to the response; an allocation sets up, scans and, when a run is found, marks it,
//   the map being read one byte (8 pages) a cycle through the single RAM read port.
// Reset: a clearing pass writes every map byte as used, with req_stall high;
//   csr writes are taken throughout.
// Stalls: one request at a time; the result register lets the next request in
//   while rsp_stall holds the last result.
`default_nettype none
module bitmap_page_allocator_unit import bpa_pkg::*; #(
   parameter int          NUM_PAGES    = 8192,
   parameter int          PAGE_SHIFT   = 12,
   parameter logic [31:0] BASE_ADDRESS = 32'h0010_0000
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [LEN_W-1:0]     req_run_length,
   input  wire logic [PIDX_W-1:0]    req_page_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ADDR_W-1:0]         rsp_address,
   output logic                      rsp_granted,
   output logic [CFG_W-1:0]          rsp_free_count,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);
   cmd_type cmd;
   sts_type sts;

   // registers are always writable
   assign csr_ready = 1'b1;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpa_dpath #(
      .NUM_PAGES    (NUM_PAGES),
      .PAGE_SHIFT   (PAGE_SHIFT),
      .BASE_ADDRESS (BASE_ADDRESS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_operation),
      .req_run_length (req_run_length),
      .req_page_index (req_page_index),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_address    (rsp_address),
      .rsp_granted    (rsp_granted),
      .rsp_free_count (rsp_free_count),
      .cmd            (cmd),
      .sts            (sts)
   );
endmodule
`default_nettype wire
